// ----- rtl/dense_layer_forward_top_defines.svh -----
// assertion macros shared by dlf_back and the top module
// each expects clk_i and rst_ni in the scope of its use
`ifndef DENSE_LAYER_FORWARD_TOP_DEFINES_SVH
`define DENSE_LAYER_FORWARD_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that holds at every clock edge out of reset
`define DLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that holds in the cycle after the antecedent
`define DLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DLF_ASSERT(lbl, prop, msg)
`define DLF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/dlf_pkg.sv -----
package dlf_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_ELEM   = 2'd2;

  // configuration register indexes
  localparam logic REG_IN_COUNT  = 1'b0;
  localparam logic REG_OUT_COUNT = 1'b1;

  localparam logic [4:0] COUNT_RESET = 5'd16;
  localparam int unsigned COUNT_HW_MAX = 16;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OQ_DEPTH  = 4;

  localparam int unsigned FRAC_BITS = 12;
  // 32-bit products, up to 16 terms plus bias, one guard bit
  localparam int unsigned ACC_W = 38;

  localparam logic signed [15:0] Q_MAX = 16'sh7fff;
  localparam logic signed [15:0] Q_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_ELEM   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               wr;
    logic               trig;
    logic [3:0]         out_idx;
    logic [3:0]         in_idx;
    logic signed [15:0] value;
    logic [4:0]         nin;
    logic [4:0]         nout;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         neuron;
    logic signed [15:0] value;
    logic               sat;
    logic               last;
  } res_t;

endpackage

// ----- rtl/dlf_fifo.sv -----
module dlf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/dlf_front.sv -----
module dlf_front #(
  parameter int unsigned IN_MAX  = 16,
  parameter int unsigned OUT_MAX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         out_index_i,
  input  logic [3:0]         in_index_i,
  input  logic signed [15:0] value_i,
  output logic               cmd_push_o,
  output dlf_pkg::cmd_t      cmd_o,
  input  logic               cmd_full_i
);

  localparam int unsigned IN_LIM  = (IN_MAX < dlf_pkg::COUNT_HW_MAX) ?
                                    IN_MAX : dlf_pkg::COUNT_HW_MAX;
  localparam int unsigned OUT_LIM = (OUT_MAX < dlf_pkg::COUNT_HW_MAX) ?
                                    OUT_MAX : dlf_pkg::COUNT_HW_MAX;

  logic [4:0] in_count_q, out_count_q;
  logic [4:0] nin, nout;
  logic       oi_ok, ii_ok, keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= dlf_pkg::COUNT_RESET;
      out_count_q <= dlf_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dlf_pkg::REG_IN_COUNT:  in_count_q  <= cfg_data_i;
        dlf_pkg::REG_OUT_COUNT: out_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero counts act as one, large counts stop at the table size or 16, whichever is smaller
  always_comb begin
    if (in_count_q == '0) begin
      nin = 5'd1;
    end else if (32'(in_count_q) > IN_LIM) begin
      nin = 5'(IN_LIM);
    end else begin
      nin = in_count_q;
    end
    if (out_count_q == '0) begin
      nout = 5'd1;
    end else if (32'(out_count_q) > OUT_LIM) begin
      nout = 5'(OUT_LIM);
    end else begin
      nout = out_count_q;
    end
  end

  assign oi_ok = (32'(out_index_i) < OUT_MAX);
  assign ii_ok = (32'(in_index_i) < IN_MAX);

  always_comb begin
    cmd_o.kind    = dlf_pkg::KIND_ELEM;
    cmd_o.wr      = 1'b0;
    cmd_o.trig    = 1'b0;
    cmd_o.out_idx = out_index_i;
    cmd_o.in_idx  = in_index_i;
    cmd_o.value   = value_i;
    cmd_o.nin     = nin;
    cmd_o.nout    = nout;
    keep          = 1'b0;
    unique case (operation_i)
      dlf_pkg::OP_WEIGHT: begin
        cmd_o.kind = dlf_pkg::KIND_WEIGHT;
        cmd_o.wr   = oi_ok && ii_ok;
        keep       = oi_ok && ii_ok;
      end
      dlf_pkg::OP_BIAS: begin
        cmd_o.kind = dlf_pkg::KIND_BIAS;
        cmd_o.wr   = oi_ok;
        keep       = oi_ok;
      end
      dlf_pkg::OP_ELEM: begin
        cmd_o.kind = dlf_pkg::KIND_ELEM;
        cmd_o.wr   = ii_ok;
        cmd_o.trig = ({1'b0, in_index_i} == (nin - 5'd1));
        keep       = ii_ok || cmd_o.trig;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i && keep;

endmodule

// ----- rtl/dlf_back.sv -----
`include "dense_layer_forward_top_defines.svh"

module dlf_back #(
  parameter int unsigned IN_MAX  = 16,
  parameter int unsigned OUT_MAX = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  dlf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output dlf_pkg::res_t res_o,
  input  logic          res_pop_i
);

  localparam int unsigned WD    = IN_MAX * OUT_MAX;
  localparam int unsigned WAW   = (WD > 1) ? $clog2(WD) : 1;
  localparam int unsigned BAW   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int unsigned RAW   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int unsigned RSV_W = $clog2(dlf_pkg::OQ_DEPTH + 1);
  localparam int unsigned QW    = dlf_pkg::ACC_W - dlf_pkg::FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_e;

  logic signed [15:0] wmem [WD];
  logic signed [15:0] bmem [OUT_MAX];
  logic signed [15:0] rmem [IN_MAX];

  back_state_e      state_q, state_d;
  logic [3:0]       t_q, t_d, j_q, j_d;
  logic [WAW-1:0]   base_q, base_d;
  logic [4:0]       nin_q, nin_d, nout_q, nout_d;
  logic [RSV_W-1:0] reserved_q, reserved_d;

  logic           issue, t_last, j_last, start_row;
  logic           wr_w, wr_b, wr_r;
  logic [WAW-1:0] waddr_wr;

  // pipeline: read, multiply, accumulate, result
  logic               s1_v_q, s1_first_q, s1_last_q, s1_rlast_q;
  logic [3:0]         s1_j_q;
  logic signed [15:0] s1_w_q, s1_row_q, s1_bias_q;
  logic               s2_v_q, s2_first_q, s2_last_q, s2_rlast_q;
  logic [3:0]         s2_j_q;
  logic signed [31:0] s2_prod_q;
  logic signed [15:0] s2_bias_q;
  logic signed [dlf_pkg::ACC_W-1:0] acc_q, prod_ext, bias_ext;
  logic               res_v_q, res_last_q;
  logic [3:0]         res_j_q;
  logic signed [QW-1:0] q;
  logic               sat_hi, sat_lo;

  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i;
  assign wr_w      = cmd_pop_o && cmd_i.wr && (cmd_i.kind == dlf_pkg::KIND_WEIGHT);
  assign wr_b      = cmd_pop_o && cmd_i.wr && (cmd_i.kind == dlf_pkg::KIND_BIAS);
  assign wr_r      = cmd_pop_o && cmd_i.wr && (cmd_i.kind == dlf_pkg::KIND_ELEM);
  assign start_row = cmd_pop_o && cmd_i.trig && (cmd_i.kind == dlf_pkg::KIND_ELEM);
  assign waddr_wr  = WAW'(32'(cmd_i.out_idx) * 32'(IN_MAX) + 32'(cmd_i.in_idx));

  assign t_last = ({1'b0, t_q} == (nin_q - 5'd1));
  assign j_last = ({1'b0, j_q} == (nout_q - 5'd1));
  // a neuron starts only with a free slot reserved in the result queue
  assign issue  = (state_q == ST_RUN) &&
                  ((t_q != '0) || (reserved_q < RSV_W'(dlf_pkg::OQ_DEPTH)));

  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    j_d        = j_q;
    base_d     = base_q;
    nin_d      = nin_q;
    nout_d     = nout_q;
    reserved_d = reserved_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_row) begin
          state_d = ST_RUN;
          t_d     = '0;
          j_d     = '0;
          base_d  = '0;
          nin_d   = cmd_i.nin;
          nout_d  = cmd_i.nout;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (t_last) begin
            t_d    = '0;
            base_d = base_q + WAW'(IN_MAX);
            if (j_last) begin
              state_d = ST_IDLE;
            end else begin
              j_d = j_q + 4'd1;
            end
          end else begin
            t_d = t_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if ((issue && (t_q == '0)) && !res_pop_i) begin
      reserved_d = reserved_q + RSV_W'(1);
    end else if (!(issue && (t_q == '0)) && res_pop_i) begin
      reserved_d = reserved_q - RSV_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      t_q        <= '0;
      j_q        <= '0;
      base_q     <= '0;
      nin_q      <= 5'd1;
      nout_q     <= 5'd1;
      reserved_q <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      res_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      t_q        <= t_d;
      j_q        <= j_d;
      base_q     <= base_d;
      nin_q      <= nin_d;
      nout_q     <= nout_d;
      reserved_q <= reserved_d;
      s1_v_q     <= issue;
      s2_v_q     <= s1_v_q;
      res_v_q    <= s2_v_q && s2_last_q;
    end
  end

  // weight, bias and row tables
  always_ff @(posedge clk_i) begin
    if (wr_w) begin
      wmem[waddr_wr] <= cmd_i.value;
    end
    if (issue) begin
      s1_w_q <= wmem[base_q + WAW'(t_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      bmem[BAW'(cmd_i.out_idx)] <= cmd_i.value;
    end
    if (issue) begin
      s1_bias_q <= bmem[BAW'(j_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_r) begin
      rmem[RAW'(cmd_i.in_idx)] <= cmd_i.value;
    end
    if (issue) begin
      s1_row_q <= rmem[RAW'(t_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_first_q <= (t_q == '0);
      s1_last_q  <= t_last;
      s1_rlast_q <= j_last;
      s1_j_q     <= j_q;
    end
    if (s1_v_q) begin
      s2_prod_q  <= s1_row_q * s1_w_q;
      s2_bias_q  <= s1_bias_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_rlast_q <= s1_rlast_q;
      s2_j_q     <= s1_j_q;
    end
    if (s2_v_q) begin
      acc_q      <= s2_first_q ? (bias_ext + prod_ext) : (acc_q + prod_ext);
      res_j_q    <= s2_j_q;
      res_last_q <= s2_rlast_q;
    end
  end

  assign prod_ext = dlf_pkg::ACC_W'(s2_prod_q);
  assign bias_ext = {{(dlf_pkg::ACC_W - 16 - dlf_pkg::FRAC_BITS){s2_bias_q[15]}},
                     s2_bias_q, {dlf_pkg::FRAC_BITS{1'b0}}};

  // floor shift, then clip to 16 bits
  assign q      = acc_q[dlf_pkg::ACC_W-1:dlf_pkg::FRAC_BITS];
  assign sat_hi = !q[QW-1] && (|q[QW-2:15]);
  assign sat_lo = q[QW-1] && !(&q[QW-2:15]);

  assign res_valid_o  = res_v_q;
  assign res_o.neuron = res_j_q;
  assign res_o.value  = sat_hi ? dlf_pkg::Q_MAX : (sat_lo ? dlf_pkg::Q_MIN : q[15:0]);
  assign res_o.sat    = sat_hi || sat_lo;
  assign res_o.last   = res_last_q;

  `DLF_ASSERT(a_res_has_slot, res_v_q |-> (reserved_q != '0), "result without reserved slot")
  `DLF_ASSERT(a_slot_bound, reserved_q <= RSV_W'(dlf_pkg::OQ_DEPTH), "reservation overrun")
  `DLF_ASSERT(a_run_in_range,
    (state_q == ST_RUN) |-> (({1'b0, t_q} < nin_q) && ({1'b0, j_q} < nout_q)),
    "loop counter beyond row shape")
  `DLF_ASSERT_NEXT(a_row_end_idle, issue && t_last && j_last, state_q == ST_IDLE,
    "row did not end after last mac")

endmodule

// ----- rtl/dense_layer_forward_top.sv -----
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+------------------------------------------
// input     | in        | push_i / full_o     | operation_i out_index_i in_index_i value_i
// result    | out       | pop_i / empty_o     | neuron_index_o result_value_o
//           |           |                     | saturated_o last_of_row_o
// config    | in        | cfg_we_i            | cfg_index_i cfg_data_i
//
// the back end takes loads only while idle; the front takes a transaction per cycle until its queue fills
// a row-closing element holds the single mac unit until the last neuron of the row is issued
// results wait in a four-entry queue; the mac unit starts a neuron only when a slot
// there is reserved, so a stalled consumer pauses it and the front keeps filling
// reset clears control state and counts to 16; the tables hold no reset value
`include "dense_layer_forward_top_defines.svh"

module dense_layer_forward_top #(
  parameter int unsigned IN_MAX  = 16,
  parameter int unsigned OUT_MAX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  // input transactions
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         out_index_i,
  input  logic [3:0]         in_index_i,
  input  logic signed [15:0] value_i,
  // result transactions
  output logic               empty_o,
  input  logic               pop_i,
  output logic [3:0]         neuron_index_o,
  output logic signed [15:0] result_value_o,
  output logic               saturated_o,
  output logic               last_of_row_o
);

  dlf_pkg::cmd_t cmd_in, cmd_out;
  dlf_pkg::res_t res_in, res_out;
  logic          cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic          res_push, res_full, res_pop;

  // front: config registers, count clamping, decode of each transaction
  dlf_front #(
    .IN_MAX  (IN_MAX),
    .OUT_MAX (OUT_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .operation_i (operation_i),
    .out_index_i (out_index_i),
    .in_index_i  (in_index_i),
    .value_i     (value_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  // decoupling queue between decode and the mac engine
  dlf_fifo #(
    .WIDTH ($bits(dlf_pkg::cmd_t)),
    .DEPTH (dlf_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // back: tables and the shared multiply-accumulate pipeline
  dlf_back #(
    .IN_MAX  (IN_MAX),
    .OUT_MAX (OUT_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_push),
    .res_o       (res_in),
    .res_pop_i   (res_pop)
  );

  // result queue, space guaranteed by the back end's reservation
  dlf_fifo #(
    .WIDTH ($bits(dlf_pkg::res_t)),
    .DEPTH (dlf_pkg::OQ_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (res_pop),
    .data_o  (res_out),
    .empty_o (empty_o)
  );

  assign res_pop = pop_i && !empty_o;

  assign neuron_index_o = res_out.neuron;
  assign result_value_o = res_out.value;
  assign saturated_o    = res_out.sat;
  assign last_of_row_o  = res_out.last;

  // the reservation keeps the result queue from overflowing
  `DLF_ASSERT(a_res_q_room, res_push |-> !res_full, "result queue overrun")
  `DLF_ASSERT(a_cmd_q_room, cmd_push |-> !cmd_full, "command queue overrun")
  // a waiting result stays put until it is taken
  `DLF_ASSERT_NEXT(a_res_held, !empty_o && !pop_i,
    !empty_o && $stable(result_value_o) && $stable(neuron_index_o),
    "waiting result changed")

endmodule
